// ===== design/mck_pkg.sv =====
// Shared types, tables and decode function for the Morse character keyer.
package mck_pkg;

    localparam int CHAR_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int DUR_W   = 19;
    localparam int LEN_W   = 3;
    localparam int PAT_W   = 5;
    localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd220;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [LEN_W-1:0]  DIGIT_LEN    = 3'd5;

    typedef enum logic [1:0] {
        CMD_GAP2,
        CMD_GAP6,
        CMD_SYMS
    } cmd_kind_t;

    typedef enum logic [1:0] {
        DUR_X1,
        DUR_X2,
        DUR_X4,
        DUR_X6
    } dur_mult_t;

    // pat is left-aligned: the current symbol is always pat[PAT_W-1], 1 = dash
    typedef struct packed {
        cmd_kind_t          kind;
        logic [LEN_W-1:0]   len;
        logic [PAT_W-1:0]   pat;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } decode_t;

    localparam logic [LEN_W-1:0] LETTER_LEN [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };

    localparam logic [PAT_W-1:0] LETTER_PAT [26] = '{
        5'd8,  5'd16, 5'd20, 5'd16, 5'd0,  5'd4,  5'd24, 5'd0,  5'd0,
        5'd14, 5'd20, 5'd8,  5'd24, 5'd16, 5'd28, 5'd12, 5'd26, 5'd8,
        5'd0,  5'd16, 5'd4,  5'd2,  5'd12, 5'd18, 5'd22, 5'd24
    };

    localparam logic [PAT_W-1:0] DIGIT_PAT [10] = '{
        5'd31, 5'd15, 5'd7, 5'd3, 5'd1, 5'd0, 5'd16, 5'd24, 5'd28, 5'd30
    };

    function automatic decode_t decode_char(input logic [CHAR_W-1:0] c);
        decode_t           d;
        logic [CHAR_W-1:0] off_l;
        logic [CHAR_W-1:0] off_d;
        off_l = c - CHAR_LOWER_A;
        off_d = c - CHAR_DIGIT_0;
        d.valid    = 1'b1;
        d.cmd.kind = CMD_SYMS;
        d.cmd.len  = '0;
        d.cmd.pat  = '0;
        if (c == CHAR_SPACE) begin
            d.cmd.kind = CMD_GAP2;
        end else if (c == CHAR_NEWLINE) begin
            d.cmd.kind = CMD_GAP6;
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d.cmd.len = LETTER_LEN[off_l[4:0]];
            d.cmd.pat = LETTER_PAT[off_l[4:0]];
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            d.cmd.len = DIGIT_LEN;
            d.cmd.pat = DIGIT_PAT[off_d[3:0]];
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== design/mck_front.sv =====
// Front end: takes character transfers, decodes them and hands commands to the queue.
module mck_front
    import mck_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CHAR_W-1:0] char_code,
    output logic              cmd_valid,
    output cmd_t              cmd_data,
    input  logic              cmd_full
);

    logic    valid_reg;
    logic    valid_next;
    cmd_t    cmd_reg;
    decode_t dec;
    logic    accept;

    assign dec       = decode_char(char_code);
    assign full      = valid_reg && cmd_full;
    assign accept    = push && !full;
    assign cmd_valid = valid_reg;
    assign cmd_data  = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = dec.valid;
        end
        else if (!cmd_full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= dec.cmd;
        end
    end

endmodule

// ===== design/mck_cmd_fifo.sv =====
// Short command queue between the front end and the segment sequencer.
module mck_cmd_fifo
    import mck_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/mck_back.sv =====
// Back end: steps through each command's segments and holds them in the output register.
module mck_back
    import mck_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              dot_time_we,
    input  logic [UNIT_W-1:0] dot_time_wdata,
    input  logic              cmd_valid,
    input  cmd_t              cmd_data,
    output logic              cmd_pop,
    output logic              empty,
    input  logic              pop,
    output logic              key_on,
    output logic [DUR_W-1:0]  duration_ms,
    output logic              last
);

    logic [UNIT_W-1:0] unit_reg;
    logic              cur_valid_reg;
    logic              cur_valid_next;
    cmd_t              cur_reg;
    cmd_t              cur_next;
    logic              off_phase_reg;
    logic              off_phase_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              key_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic              last_reg;

    logic              seg_key;
    dur_mult_t         seg_mult;
    logic              seg_last;
    logic [DUR_W-1:0]  seg_dur;
    logic              emit;
    logic              load;

    function automatic logic [DUR_W-1:0] scale(input logic [UNIT_W-1:0] u, input dur_mult_t m);
        logic [DUR_W-1:0] x1;
        logic [DUR_W-1:0] r;
        x1 = DUR_W'(u);
        case (m)
            DUR_X1:  r = x1;
            DUR_X2:  r = x1 << 1;
            DUR_X4:  r = x1 << 2;
            DUR_X6:  r = (x1 << 2) + (x1 << 1);
            default: r = x1;
        endcase
        return r;
    endfunction

    always_comb
    begin
        seg_key  = 1'b0;
        seg_mult = DUR_X1;
        seg_last = 1'b1;
        unique case (cur_reg.kind)
            CMD_GAP2:
            begin
                seg_mult = DUR_X2;
            end
            CMD_GAP6:
            begin
                seg_mult = DUR_X6;
            end
            CMD_SYMS:
            begin
                if (!off_phase_reg)
                begin
                    seg_key  = 1'b1;
                    seg_mult = cur_reg.pat[PAT_W-1] ? DUR_X4 : DUR_X1;
                    seg_last = 1'b0;
                end
                else
                begin
                    seg_last = (cur_reg.len == LEN_W'(1));
                end
            end
            default:
            begin
                seg_last = 1'b1;
            end
        endcase
    end

    assign seg_dur = scale(unit_reg, seg_mult);
    assign emit    = cur_valid_reg && (!out_valid_reg || pop);
    assign load    = !cur_valid_reg || (emit && seg_last);
    assign cmd_pop = load && cmd_valid;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        off_phase_next = off_phase_reg;
        if (load)
        begin
            cur_valid_next = cmd_valid;
            cur_next       = cmd_data;
            off_phase_next = 1'b0;
        end
        else if (emit && cur_reg.kind == CMD_SYMS)
        begin
            if (off_phase_reg)
            begin
                off_phase_next = 1'b0;
                cur_next.len   = cur_reg.len - 1'b1;
                cur_next.pat   = cur_reg.pat << 1;
            end
            else
            begin
                off_phase_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg      <= UNIT_RESET;
            cur_valid_reg <= 1'b0;
            off_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (dot_time_we)
            begin
                unit_reg <= dot_time_wdata;
            end
            cur_valid_reg <= cur_valid_next;
            off_phase_reg <= off_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            key_reg  <= seg_key;
            dur_reg  <= seg_dur;
            last_reg <= seg_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign key_on      = key_reg;
    assign duration_ms = dur_reg;
    assign last        = last_reg;

endmodule

// ===== design/morse_character_keyer_core.sv =====
// Top level of the Morse character keyer: front decoder, command queue, segment sequencer.
// A character is registered in the front end, queued in the command FIFO and loaded into
// the segment sequencer, whose output register holds each segment. The sequencer gives
// one segment per cycle while pop is high; a character has 1 segment for space or newline
// and 2 to 10 for letters and digits. Codes that send nothing produce no transfer.
// Reset (rst_n low, asynchronous) empties all stages and sets dot_time to 220.
module morse_character_keyer_core
    import mck_pkg::*;
#(
    parameter int CMD_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CHAR_W-1:0] char_code,
    output logic              empty,
    input  logic              pop,
    output logic              key_on,
    output logic [DUR_W-1:0]  duration_ms,
    output logic              last,
    input  logic              dot_time_we,
    input  logic [UNIT_W-1:0] dot_time_wdata
);

    logic cf_wr;
    cmd_t cf_wr_data;
    logic cf_full;
    logic cf_rd;
    cmd_t cf_rd_data;
    logic cf_not_empty;

    mck_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_code (char_code),
        .cmd_valid (cf_wr),
        .cmd_data  (cf_wr_data),
        .cmd_full  (cf_full)
    );

    mck_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cf_wr),
        .wr_data   (cf_wr_data),
        .full      (cf_full),
        .rd_en     (cf_rd),
        .rd_data   (cf_rd_data),
        .not_empty (cf_not_empty)
    );

    mck_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .dot_time_we    (dot_time_we),
        .dot_time_wdata (dot_time_wdata),
        .cmd_valid      (cf_not_empty),
        .cmd_data       (cf_rd_data),
        .cmd_pop        (cf_rd),
        .empty          (empty),
        .pop            (pop),
        .key_on         (key_on),
        .duration_ms    (duration_ms),
        .last           (last)
    );

endmodule

// ===== design/mck_checker.sv =====
// Port-level checks for the Morse character keyer, bound to the top level.
module mck_checker
    import mck_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input logic             key_on,
    input logic [DUR_W-1:0] duration_ms,
    input logic             last
);

    localparam logic [DUR_W-1:0] DUR_MAX = 19'd393210;

    a_key_down_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && key_on) |-> !last)
        else $error("key-down segment flagged as last");

    a_key_down_then_up: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(pop && !empty && key_on) && !empty) |-> !key_on)
        else $error("key-down segment not followed by key-up segment");

    a_dur_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (duration_ms <= DUR_MAX))
        else $error("segment duration out of range");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(key_on) && $stable(duration_ms)
                              && $stable(last)))
        else $error("result changed while stalled");

endmodule

bind morse_character_keyer_core mck_checker u_mck_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .key_on      (key_on),
    .duration_ms (duration_ms),
    .last        (last)
);

// ===== tb/sv/morse_character_keyer_core_tb.sv =====
// Testbench for the Morse character keyer: directed and random characters checked segment by segment.
module morse_character_keyer_core_tb;
    import mck_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic             key_on;
        logic [DUR_W-1:0] dur;
        logic             last;
    } key_seg_t;

    // symbol patterns right-aligned, first symbol in the highest used bit, 1 = dash
    localparam logic [2:0] SYM_COUNT [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [3:0] SYM_PAT [26] = '{
        4'd1, 4'd8, 4'd10, 4'd4, 4'd0, 4'd2, 4'd6, 4'd0, 4'd0, 4'd7, 4'd5, 4'd4, 4'd3,
        4'd2, 4'd7, 4'd6, 4'd13, 4'd2, 4'd0, 4'd1, 4'd1, 4'd1, 4'd3, 4'd9, 4'd11, 4'd12
    };
    localparam logic [4:0] NUM_PAT [10] = '{
        5'd31, 5'd15, 5'd7, 5'd3, 5'd1, 5'd0, 5'd16, 5'd24, 5'd28, 5'd30
    };

    localparam logic [CHAR_W-1:0] EDGE_CHARS [23] = '{
        8'h00, 8'hFF, CHAR_SPACE, CHAR_NEWLINE, CHAR_LOWER_A, CHAR_LOWER_Z,
        CHAR_DIGIT_0, CHAR_DIGIT_9, "n", "e", "t", "A", "Z", 8'h2F, 8'h3A,
        8'h60, 8'h7B, 8'h7F, 8'h80, 8'h09, 8'h0B, "q", "5"
    };

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              push           = 1'b0;
    logic              pop            = 1'b0;
    logic [CHAR_W-1:0] char_code      = '0;
    logic              dot_time_we    = 1'b0;
    logic [UNIT_W-1:0] dot_time_wdata = '0;
    logic              full;
    logic              empty;
    logic              key_on;
    logic [DUR_W-1:0]  duration_ms;
    logic              last;

    logic [CHAR_W-1:0] pending_chars [$];
    key_seg_t          expected_segs [$];
    key_seg_t          head_seg;
    logic [UNIT_W-1:0] unit_ms         = UNIT_RESET;
    int                send_idle_pct   = 0;
    int                recv_idle_pct   = 0;
    int                error_count     = 0;
    int                chars_accepted  = 0;
    int                chars_ignored   = 0;
    int                segs_checked    = 0;
    int                settings_used   = 1;
    int                stall_cycles    = 0;

    morse_character_keyer_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .char_code      (char_code),
        .empty          (empty),
        .pop            (pop),
        .key_on         (key_on),
        .duration_ms    (duration_ms),
        .last           (last),
        .dot_time_we    (dot_time_we),
        .dot_time_wdata (dot_time_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_sendable(input logic [CHAR_W-1:0] c);
        return c == CHAR_SPACE || c == CHAR_NEWLINE ||
               (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
               (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9);
    endfunction

    function automatic void add_segment(input logic on, input int unsigned mult, input logic fin);
        key_seg_t s;
        s.key_on = on;
        s.dur    = DUR_W'(mult * unit_ms);
        s.last   = fin;
        expected_segs.push_back(s);
    endfunction

    function automatic void predict_segments(input logic [CHAR_W-1:0] c);
        int unsigned nsym;
        int unsigned pat;
        nsym = 0;
        pat  = 0;
        if (c == CHAR_SPACE)
        begin
            add_segment(1'b0, 2, 1'b1);
        end
        else if (c == CHAR_NEWLINE)
        begin
            add_segment(1'b0, 6, 1'b1);
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            nsym = SYM_COUNT[c - CHAR_LOWER_A];
            pat  = SYM_PAT[c - CHAR_LOWER_A];
        end
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
        begin
            nsym = 5;
            pat  = NUM_PAT[c - CHAR_DIGIT_0];
        end
        for (int i = int'(nsym) - 1; i >= 0; i--)
        begin
            add_segment(1'b1, pat[i] ? 4 : 1, 1'b0);
            add_segment(1'b0, 1, i == 0);
        end
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45)
            return CHAR_LOWER_A + CHAR_W'($urandom_range(25));
        else if (r < 65)
            return CHAR_DIGIT_0 + CHAR_W'($urandom_range(9));
        else if (r < 72)
            return CHAR_SPACE;
        else if (r < 77)
            return CHAR_NEWLINE;
        else
            return CHAR_W'($urandom_range(255));
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                predict_segments(char_code);
                chars_accepted++;
                if (!is_sendable(char_code))
                    chars_ignored++;
            end
            if (!push || !full)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push      <= 1'b1;
                    char_code <= pending_chars.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver and segment check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
            if (pop && !empty)
            begin
                if (expected_segs.size() == 0)
                begin
                    $error("unexpected segment: key_on %0d duration_ms %0d last %0d",
                           key_on, duration_ms, last);
                    error_count++;
                end
                else
                begin
                    head_seg = expected_segs.pop_front();
                    segs_checked++;
                    if (key_on !== head_seg.key_on)
                    begin
                        $error("key_on: expected %0d, actual %0d", head_seg.key_on, key_on);
                        error_count++;
                    end
                    if (duration_ms !== head_seg.dur)
                    begin
                        $error("duration_ms: expected %0d, actual %0d",
                               head_seg.dur, duration_ms);
                        error_count++;
                    end
                    if (last !== head_seg.last)
                    begin
                        $error("last: expected %0d, actual %0d", head_seg.last, last);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // checked at the falling edge so the sender's updates have settled
    task automatic wait_idle();
        @(negedge clk);
        while (pending_chars.size() != 0 || push || expected_segs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_unit(input logic [UNIT_W-1:0] v);
        wait_idle();
        dot_time_we    <= 1'b1;
        dot_time_wdata <= v;
        @(posedge clk);
        dot_time_we <= 1'b0;
        unit_ms = v;
        settings_used++;
    endtask

    task automatic run_random(input int n_keyed, input int send_pct, input int recv_pct);
        int                made;
        logic [CHAR_W-1:0] c;
        made = 0;
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (made < n_keyed)
        begin
            c = pick_char();
            pending_chars.push_back(c);
            if (is_sendable(c))
                made++;
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n         = 1'b1;
        send_idle_pct = 38;
        recv_idle_pct = 73;
        foreach (EDGE_CHARS[i])
            pending_chars.push_back(EDGE_CHARS[i]);

        write_unit(16'hFFFF);
        run_random(48, 38, 73);
        write_unit(16'd0);
        run_random(16, 38, 73);
        write_unit(16'd1);
        run_random(36, 73, 38);
        wait_idle();
        run_random(36, 73, 38);
        write_unit(UNIT_W'($urandom_range(65534, 2)));
        run_random(48, 0, 0);
        wait_idle();

        $display("Sent %0d characters (%0d with no segments), checked %0d segments",
                 chars_accepted, chars_ignored, segs_checked);
        $display("Used %0d dot_time settings: reset value, 0, 1, 65535 and a random one",
                 settings_used);
        if (error_count == 0 && expected_segs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
